### src/i2crm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master: shared types and constants
// Phase and stage codes, request and result records, and sequencer state.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_ST_C = 5'd3,
        PH_ST_D = 5'd4,
        PH_ST_E = 5'd5,
        PH_TX_A = 5'd6,
        PH_TX_B = 5'd7,
        PH_TX_C = 5'd8,
        PH_TX_D = 5'd9,
        PH_TX_E = 5'd10,
        PH_AK_A = 5'd11,
        PH_AK_B = 5'd12,
        PH_AK_C = 5'd13,
        PH_AK_D = 5'd14,
        PH_RX_A = 5'd15,
        PH_RX_B = 5'd16,
        PH_RX_C = 5'd17,
        PH_RX_D = 5'd18,
        PH_RX_E = 5'd19,
        PH_NK_A = 5'd20,
        PH_NK_B = 5'd21,
        PH_NK_C = 5'd22,
        PH_NK_D = 5'd23,
        PH_SP_A = 5'd24,
        PH_SP_B = 5'd25,
        PH_SP_C = 5'd26,
        PH_SP_D = 5'd27,
        PH_SP_E = 5'd28
    } phase_t;

    typedef enum logic [2:0] {
        SG_START1 = 3'd0,
        SG_ADDR_W = 3'd1,
        SG_OFFSET = 3'd2,
        SG_RSTART = 3'd3,
        SG_ADDR_R = 3'd4,
        SG_READ   = 3'd5,
        SG_DATA   = 3'd6,
        SG_STOP   = 3'd7
    } stage_t;

    localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd100;
    localparam logic [7:0] ADDR_WRITE_MASK     = 8'hfe;
    localparam logic [7:0] ADDR_READ_BIT       = 8'h01;
    localparam logic [3:0] BITS_PER_BYTE       = 4'd8;
    // most sequencer steps that one tick can chain together
    localparam int ITER_MAX = 5;

    typedef struct packed {
        op_t        op;
        logic [7:0] device_address;
        logic [7:0] register_offset;
        logic [7:0] write_data;
        logic       sda_in;
        logic       scl_in;
    } in_item_t;

    typedef struct packed {
        logic       sda_release;
        logic       scl_release;
        logic       busy_res;
        logic       done_res;
        logic       acked;
        logic [7:0] read_data;
        logic       cmd_rejected;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        stage_t     stage;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [2:0] delay_count;
        logic [7:0] stretch_count;
        logic       all_acked;
        logic       sda_level;
        logic       scl_level;
    } seq_state_t;

    typedef struct packed {
        seq_state_t st;
        logic       halt;
    } step_t;

endpackage : i2crm_pkg
`default_nettype wire

### src/i2crm_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master: request register
// Holds one accepted request until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2crm_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire i2crm_pkg::in_item_t item_in,
    input  wire logic                take,
    output logic                     item_valid,
    output i2crm_pkg::in_item_t      item
);
    import i2crm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule : i2crm_in_stage
`default_nettype wire

### src/i2crm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master: bus sequencer
// Advances the bus state by one request: a command or one microsecond tick.
// ----------------------------------------------------------------------------
module i2crm_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire i2crm_pkg::in_item_t item,
    input  wire logic [7:0]          stretch_limit,
    output i2crm_pkg::result_t       result
);
    import i2crm_pkg::*;

    seq_state_t st_reg;
    seq_state_t st_next;
    logic [7:0] addr_reg;
    logic [7:0] addr_next;
    logic [7:0] offset_reg;
    logic [7:0] offset_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       is_read_reg;
    logic       is_read_next;
    logic       busy;
    logic       done;
    logic       rejected;
    step_t      chain [ITER_MAX + 1];

    // One zero-time action, or one tick of delay, of the bus sequence.
    function automatic step_t step_iter(
        input step_t      s,
        input logic       sda_in,
        input logic       scl_in,
        input logic [7:0] limit,
        input logic [7:0] addr,
        input logic [7:0] offset,
        input logic [7:0] data,
        input logic       is_read
    );
        step_t r;
        logic  risen;
        r     = s;
        risen = scl_in || (s.st.stretch_count >= limit);
        if (!s.halt)
        begin
            if (s.st.delay_count != 3'd0)
            begin
                r.st.delay_count = s.st.delay_count - 3'd1;
                r.halt           = 1'b1;
            end
            else
            begin
                unique case (s.st.phase)
                    PH_ST_A:
                    begin
                        r.st.sda_level = 1'b1;
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd5;
                            r.st.phase         = PH_ST_C;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_ST_C:
                    begin
                        r.st.sda_level   = 1'b0;
                        r.st.delay_count = 3'd4;
                        r.st.phase       = PH_ST_D;
                    end
                    PH_ST_D:
                    begin
                        r.st.scl_level   = 1'b0;
                        r.st.delay_count = 3'd5;
                        r.st.phase       = PH_ST_E;
                    end
                    PH_ST_E:
                    begin
                        r.st.bit_count = BITS_PER_BYTE;
                        r.st.phase     = PH_TX_A;
                        if (s.st.stage == SG_RSTART)
                        begin
                            r.st.stage      = SG_ADDR_R;
                            r.st.shift_byte = addr | ADDR_READ_BIT;
                        end
                        else
                        begin
                            r.st.stage      = SG_ADDR_W;
                            r.st.shift_byte = addr & ADDR_WRITE_MASK;
                        end
                    end
                    PH_TX_A:
                    begin
                        r.st.sda_level   = s.st.shift_byte[7];
                        r.st.delay_count = 3'd1;
                        r.st.phase       = PH_TX_B;
                    end
                    PH_TX_B:
                    begin
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_TX_C;
                    end
                    PH_TX_C:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd4;
                            r.st.phase         = PH_TX_D;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_TX_D:
                    begin
                        r.st.scl_level   = 1'b0;
                        r.st.delay_count = 3'd6;
                        r.st.phase       = PH_TX_E;
                    end
                    PH_TX_E:
                    begin
                        r.st.shift_byte = {s.st.shift_byte[6:0], 1'b0};
                        r.st.bit_count  = s.st.bit_count - 4'd1;
                        r.st.phase      = (s.st.bit_count != 4'd1) ? PH_TX_A : PH_AK_A;
                    end
                    PH_AK_A:
                    begin
                        r.st.sda_level = 1'b1;
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_AK_B;
                    end
                    PH_AK_B:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd4;
                            r.st.phase         = PH_AK_C;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_AK_C:
                    begin
                        if (sda_in)
                        begin
                            r.st.all_acked = 1'b0;
                        end
                        r.st.scl_level   = 1'b0;
                        r.st.delay_count = 3'd5;
                        r.st.phase       = PH_AK_D;
                    end
                    PH_AK_D:
                    begin
                        priority if (!s.st.all_acked || s.st.stage == SG_DATA)
                        begin
                            r.st.stage = SG_STOP;
                            r.st.phase = PH_SP_A;
                        end
                        else if (s.st.stage == SG_ADDR_W)
                        begin
                            r.st.stage      = SG_OFFSET;
                            r.st.shift_byte = offset;
                            r.st.bit_count  = BITS_PER_BYTE;
                            r.st.phase      = PH_TX_A;
                        end
                        else if (s.st.stage == SG_OFFSET && is_read)
                        begin
                            r.st.stage = SG_RSTART;
                            r.st.phase = PH_ST_A;
                        end
                        else if (s.st.stage == SG_OFFSET)
                        begin
                            r.st.stage      = SG_DATA;
                            r.st.shift_byte = data;
                            r.st.bit_count  = BITS_PER_BYTE;
                            r.st.phase      = PH_TX_A;
                        end
                        else if (s.st.stage == SG_ADDR_R)
                        begin
                            r.st.stage = SG_READ;
                            r.st.phase = PH_RX_A;
                        end
                        else
                        begin
                            r.st.stage = SG_STOP;
                            r.st.phase = PH_SP_A;
                        end
                    end
                    PH_RX_A:
                    begin
                        r.st.sda_level  = 1'b1;
                        r.st.shift_byte = 8'd0;
                        r.st.bit_count  = BITS_PER_BYTE;
                        r.st.phase      = PH_RX_B;
                    end
                    PH_RX_B:
                    begin
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_RX_C;
                    end
                    PH_RX_C:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd4;
                            r.st.phase         = PH_RX_D;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_RX_D:
                    begin
                        r.st.shift_byte  = {s.st.shift_byte[6:0], sda_in};
                        r.st.scl_level   = 1'b0;
                        r.st.delay_count = 3'd5;
                        r.st.phase       = PH_RX_E;
                    end
                    PH_RX_E:
                    begin
                        r.st.bit_count = s.st.bit_count - 4'd1;
                        r.st.phase     = (s.st.bit_count != 4'd1) ? PH_RX_B : PH_NK_A;
                    end
                    PH_NK_A:
                    begin
                        r.st.sda_level   = 1'b1;
                        r.st.delay_count = 3'd1;
                        r.st.phase       = PH_NK_B;
                    end
                    PH_NK_B:
                    begin
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_NK_C;
                    end
                    PH_NK_C:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd4;
                            r.st.phase         = PH_NK_D;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_NK_D:
                    begin
                        r.st.scl_level   = 1'b0;
                        r.st.delay_count = 3'd6;
                        r.st.stage       = SG_STOP;
                        r.st.phase       = PH_SP_A;
                    end
                    PH_SP_A:
                    begin
                        r.st.sda_level   = 1'b0;
                        r.st.delay_count = 3'd1;
                        r.st.phase       = PH_SP_B;
                    end
                    PH_SP_B:
                    begin
                        r.st.scl_level = 1'b1;
                        r.st.phase     = PH_SP_C;
                    end
                    PH_SP_C:
                    begin
                        if (risen)
                        begin
                            r.st.stretch_count = 8'd0;
                            r.st.delay_count   = 3'd4;
                            r.st.phase         = PH_SP_D;
                        end
                        else
                        begin
                            r.st.stretch_count = s.st.stretch_count + 8'd1;
                            r.halt             = 1'b1;
                        end
                    end
                    PH_SP_D:
                    begin
                        r.st.sda_level   = 1'b1;
                        r.st.delay_count = 3'd5;
                        r.st.phase       = PH_SP_E;
                    end
                    default:
                    begin
                        r.halt = 1'b1;
                    end
                endcase
            end
        end
        return r;
    endfunction

    assign busy = (st_reg.phase != PH_IDLE);

    always_comb
    begin
        chain[0] = '{st: st_reg, halt: 1'b0};
        for (int i = 0; i < ITER_MAX; i++)
        begin
            chain[i + 1] = step_iter(chain[i], item.sda_in, item.scl_in, stretch_limit,
                                     addr_reg, offset_reg, data_reg, is_read_reg);
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        addr_next    = addr_reg;
        offset_next  = offset_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        done         = 1'b0;
        rejected     = 1'b0;
        if (fire)
        begin
            if (item.op == OP_READ || item.op == OP_WRITE)
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    addr_next             = item.device_address;
                    offset_next           = item.register_offset;
                    data_next             = item.write_data;
                    is_read_next          = (item.op == OP_READ);
                    st_next.all_acked     = 1'b1;
                    st_next.stage         = SG_START1;
                    st_next.bit_count     = 4'd0;
                    st_next.shift_byte    = 8'd0;
                    st_next.delay_count   = 3'd0;
                    st_next.stretch_count = 8'd0;
                    st_next.phase         = PH_ST_A;
                end
            end
            else if (item.op == OP_TICK && busy)
            begin
                st_next = chain[ITER_MAX].st;
                // end of the final stop wait
                if (chain[ITER_MAX].st.phase == PH_SP_E &&
                    chain[ITER_MAX].st.delay_count == 3'd0)
                begin
                    st_next.phase = PH_IDLE;
                    done          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase         <= PH_IDLE;
            st_reg.stage         <= SG_START1;
            st_reg.bit_count     <= 4'd0;
            st_reg.shift_byte    <= 8'd0;
            st_reg.delay_count   <= 3'd0;
            st_reg.stretch_count <= 8'd0;
            st_reg.all_acked     <= 1'b1;
            st_reg.sda_level     <= 1'b1;
            st_reg.scl_level     <= 1'b1;
            addr_reg             <= 8'd0;
            offset_reg           <= 8'd0;
            data_reg             <= 8'd0;
            is_read_reg          <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            addr_reg    <= addr_next;
            offset_reg  <= offset_next;
            data_reg    <= data_next;
            is_read_reg <= is_read_next;
        end
    end

    always_comb
    begin
        result.sda_release  = st_next.sda_level;
        result.scl_release  = st_next.scl_level;
        result.busy_res     = (st_next.phase != PH_IDLE);
        result.done_res     = done;
        result.acked        = done && st_next.all_acked;
        result.read_data    = (done && is_read_reg && st_next.all_acked) ?
                              st_next.shift_byte : 8'd0;
        result.cmd_rejected = rejected;
    end

endmodule : i2crm_seq
`default_nettype wire

### src/i2crm_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master: result register
// Holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
module i2crm_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire i2crm_pkg::result_t res_in,
    output logic                    can_load,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output i2crm_pkg::result_t      res_out
);
    import i2crm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule : i2crm_out_stage
`default_nettype wire

### src/i2c_register_access_master_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master
// Open-drain register read and write master paced by microsecond tick requests.
// ----------------------------------------------------------------------------
// Each request (a tick, a read command or a write command) yields exactly one
// result. A request is held in the request register, then the bus sequencer
// advances the whole microsecond step combinationally and the result lands in
// the result register. A new request is taken every cycle while the output
// side is not stalled, so throughput is one request per clock. Line levels for
// SDA and SCL come back with each result; done_res, acked and read_data close
// each transaction. The user writes stretch_limit through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module i2c_register_access_master_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic [7:0] device_address,
    input  wire logic [7:0] register_offset,
    input  wire logic [7:0] write_data,
    input  wire logic       sda_in,
    input  wire logic       scl_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            sda_release,
    output logic            scl_release,
    output logic            busy_res,
    output logic            done_res,
    output logic            acked,
    output logic [7:0]      read_data,
    output logic            cmd_rejected
);
    import i2crm_pkg::*;

    logic [7:0] stretch_limit_reg;
    in_item_t   item_in;
    in_item_t   item;
    logic       item_valid;
    logic       can_load;
    logic       take;
    result_t    res_in;
    result_t    res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stretch_limit_reg <= STRETCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            stretch_limit_reg <= cfg_wdata;
        end
    end

    assign item_in.op              = op_t'(op);
    assign item_in.device_address  = device_address;
    assign item_in.register_offset = register_offset;
    assign item_in.write_data      = write_data;
    assign item_in.sda_in          = sda_in;
    assign item_in.scl_in          = scl_in;

    assign take = item_valid && can_load;

    i2crm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    i2crm_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (take),
        .item          (item),
        .stretch_limit (stretch_limit_reg),
        .result        (res_in)
    );

    i2crm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res_in),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign sda_release  = res_out.sda_release;
    assign scl_release  = res_out.scl_release;
    assign busy_res     = res_out.busy_res;
    assign done_res     = res_out.done_res;
    assign acked        = res_out.acked;
    assign read_data    = res_out.read_data;
    assign cmd_rejected = res_out.cmd_rejected;

    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("transaction finished but still busy");

    a_done_not_rejected : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && cmd_rejected))
        else $error("one request both finished and rejected");

    a_acked_with_done : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && acked |-> done_res)
        else $error("acked without done");

    a_data_with_done : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != 8'd0) |-> done_res && acked)
        else $error("read data outside a finished acknowledged read");

    a_take_moves_request : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("consumed request left no result");

endmodule : i2c_register_access_master_unit
`default_nettype wire

### tb/i2c_register_access_master_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register access master: request/result checker
// Mirrors the bus sequencer for every accepted request, queues the expected
// line levels and transaction status, and compares each accepted result.
// ----------------------------------------------------------------------------
module i2c_register_access_master_unit_checker
    import i2crm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] device_address,
    input  logic [7:0] register_offset,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    input  logic       scl_in,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       sda_release,
    input  logic       scl_release,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic       acked,
    input  logic [7:0] read_data,
    input  logic       cmd_rejected,
    output int         fail_count,
    output int         pending,
    output phase_t     bus_phase,
    output logic       bus_active,
    output int         tally_requests,
    output int         tally_done,
    output int         tally_acked,
    output int         tally_rejected
);

    // mirrored sequencer state
    logic [7:0] stretch_lim;
    phase_t     seq_phase;
    stage_t     seq_stage;
    logic [3:0] bits_left;
    logic [7:0] shreg;
    logic [2:0] hold_cnt;
    logic [7:0] stretch_cnt;
    logic [7:0] adr_lat;
    logic [7:0] ofs_lat;
    logic [7:0] dat_lat;
    logic       rd_mode;
    logic       acks_ok;
    logic       sda_drv;
    logic       scl_drv;

    result_t    line_results_q[$];
    result_t    want;

    function automatic void clear_sequencer();
        stretch_lim = STRETCH_LIMIT_RESET;
        seq_phase   = PH_IDLE;
        seq_stage   = SG_START1;
        bits_left   = '0;
        shreg       = '0;
        hold_cnt    = '0;
        stretch_cnt = '0;
        adr_lat     = '0;
        ofs_lat     = '0;
        dat_lat     = '0;
        rd_mode     = 1'b0;
        acks_ok     = 1'b1;
        sda_drv     = 1'b1;
        scl_drv     = 1'b1;
    endfunction

    // SCL released: proceed once the line is high or the stretch budget is spent
    function automatic logic scl_ready(logic scl);
        if (scl || stretch_cnt >= stretch_lim)
        begin
            stretch_cnt = '0;
            return 1'b1;
        end
        stretch_cnt = stretch_cnt + 8'd1;
        return 1'b0;
    endfunction

    function automatic void shift_out(stage_t s, logic [7:0] b);
        seq_stage = s;
        shreg     = b;
        bits_left = BITS_PER_BYTE;
        seq_phase = PH_TX_A;
    endfunction

    function automatic void enter_stop();
        seq_stage = SG_STOP;
        seq_phase = PH_SP_A;
    endfunction

    // One zero-time bus action; returns 1 when the microsecond is used up.
    function automatic logic bus_action(logic sda, logic scl);
        logic spent;
        spent = 1'b0;
        case (seq_phase)
            PH_ST_A:
            begin
                sda_drv = 1'b1; scl_drv = 1'b1; seq_phase = PH_ST_B;
            end
            PH_ST_B:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd5; seq_phase = PH_ST_C;
                end
            PH_ST_C:
            begin
                sda_drv = 1'b0; hold_cnt = 3'd4; seq_phase = PH_ST_D;
            end
            PH_ST_D:
            begin
                scl_drv = 1'b0; hold_cnt = 3'd5; seq_phase = PH_ST_E;
            end
            PH_ST_E:
                if (seq_stage == SG_RSTART) shift_out(SG_ADDR_R, adr_lat | ADDR_READ_BIT);
                else shift_out(SG_ADDR_W, adr_lat & ADDR_WRITE_MASK);
            PH_TX_A:
            begin
                sda_drv = shreg[7]; hold_cnt = 3'd1; seq_phase = PH_TX_B;
            end
            PH_TX_B:
            begin
                scl_drv = 1'b1; seq_phase = PH_TX_C;
            end
            PH_TX_C:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd4; seq_phase = PH_TX_D;
                end
            PH_TX_D:
            begin
                scl_drv = 1'b0; hold_cnt = 3'd6; seq_phase = PH_TX_E;
            end
            PH_TX_E:
            begin
                shreg     = {shreg[6:0], 1'b0};
                bits_left = bits_left - 4'd1;
                seq_phase = (bits_left != 0) ? PH_TX_A : PH_AK_A;
            end
            PH_AK_A:
            begin
                sda_drv = 1'b1; scl_drv = 1'b1; seq_phase = PH_AK_B;
            end
            PH_AK_B:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd4; seq_phase = PH_AK_C;
                end
            PH_AK_C:
            begin
                if (sda) acks_ok = 1'b0;
                scl_drv = 1'b0; hold_cnt = 3'd5; seq_phase = PH_AK_D;
            end
            PH_AK_D:
                // decide what follows the acknowledged byte
                if (!acks_ok || seq_stage == SG_DATA) enter_stop();
                else if (seq_stage == SG_ADDR_W) shift_out(SG_OFFSET, ofs_lat);
                else if (seq_stage == SG_OFFSET && rd_mode)
                begin
                    seq_stage = SG_RSTART; seq_phase = PH_ST_A;
                end
                else if (seq_stage == SG_OFFSET) shift_out(SG_DATA, dat_lat);
                else if (seq_stage == SG_ADDR_R)
                begin
                    seq_stage = SG_READ; seq_phase = PH_RX_A;
                end
                else enter_stop();
            PH_RX_A:
            begin
                sda_drv = 1'b1; shreg = '0; bits_left = BITS_PER_BYTE; seq_phase = PH_RX_B;
            end
            PH_RX_B:
            begin
                scl_drv = 1'b1; seq_phase = PH_RX_C;
            end
            PH_RX_C:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd4; seq_phase = PH_RX_D;
                end
            PH_RX_D:
            begin
                shreg = {shreg[6:0], sda};
                scl_drv = 1'b0; hold_cnt = 3'd5; seq_phase = PH_RX_E;
            end
            PH_RX_E:
            begin
                bits_left = bits_left - 4'd1;
                seq_phase = (bits_left != 0) ? PH_RX_B : PH_NK_A;
            end
            PH_NK_A:
            begin
                sda_drv = 1'b1; hold_cnt = 3'd1; seq_phase = PH_NK_B;
            end
            PH_NK_B:
            begin
                scl_drv = 1'b1; seq_phase = PH_NK_C;
            end
            PH_NK_C:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd4; seq_phase = PH_NK_D;
                end
            PH_NK_D:
            begin
                scl_drv = 1'b0; hold_cnt = 3'd6; enter_stop();
            end
            PH_SP_A:
            begin
                sda_drv = 1'b0; hold_cnt = 3'd1; seq_phase = PH_SP_B;
            end
            PH_SP_B:
            begin
                scl_drv = 1'b1; seq_phase = PH_SP_C;
            end
            PH_SP_C:
                if (!scl_ready(scl)) spent = 1'b1;
                else
                begin
                    hold_cnt = 3'd4; seq_phase = PH_SP_D;
                end
            PH_SP_D:
            begin
                sda_drv = 1'b1; hold_cnt = 3'd5; seq_phase = PH_SP_E;
            end
            default:
                spent = 1'b1;
        endcase
        return spent;
    endfunction

    // Advance one microsecond; returns 1 on the tick that ends the stop wait.
    function automatic logic advance_us(logic sda, logic scl);
        int   guard;
        logic halt;
        halt = 1'b0;
        for (guard = 0; guard < 32 && !halt; guard++)
        begin
            if (hold_cnt != 0)
            begin
                hold_cnt = hold_cnt - 3'd1;
                halt = 1'b1;
            end
            else if (bus_action(sda, scl))
                halt = 1'b1;
        end
        if (seq_phase == PH_SP_E && hold_cnt == 0)
        begin
            seq_phase = PH_IDLE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t predict_bus(logic [1:0] code_bits, logic [7:0] a,
                                            logic [7:0] o, logic [7:0] d,
                                            logic sda, logic scl);
        result_t r;
        op_t     code;
        logic    fin;
        logic    rej;
        code = op_t'(code_bits);
        fin  = 1'b0;
        rej  = 1'b0;
        if (code == OP_READ || code == OP_WRITE)
        begin
            if (seq_phase != PH_IDLE)
                rej = 1'b1;
            else
            begin
                adr_lat     = a;
                ofs_lat     = o;
                dat_lat     = d;
                rd_mode     = (code == OP_READ);
                acks_ok     = 1'b1;
                seq_stage   = SG_START1;
                bits_left   = '0;
                shreg       = '0;
                hold_cnt    = '0;
                stretch_cnt = '0;
                seq_phase   = PH_ST_A;
            end
        end
        else if (code == OP_TICK && seq_phase != PH_IDLE)
            fin = advance_us(sda, scl);

        r.sda_release  = sda_drv;
        r.scl_release  = scl_drv;
        r.busy_res     = (seq_phase != PH_IDLE);
        r.done_res     = fin;
        r.acked        = fin && acks_ok;
        r.read_data    = (fin && rd_mode && acks_ok) ? shreg : 8'h00;
        r.cmd_rejected = rej;
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            if (fail_count < 100)
                $display("%0t: %s expected %0h actual %0h", $time, label, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequencer();
            line_results_q.delete();
            fail_count     <= 0;
            tally_requests <= 0;
            tally_done     <= 0;
            tally_acked    <= 0;
            tally_rejected <= 0;
            pending        = 0;
            bus_phase      = PH_IDLE;
            bus_active     = 1'b0;
        end
        else
        begin
            if (cfg_we)
                stretch_lim = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                line_results_q.push_back(predict_bus(op, device_address, register_offset,
                                                     write_data, sda_in, scl_in));
                tally_requests <= tally_requests + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (line_results_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual done %0b data %0h",
                             $time, done_res, read_data);
                    fail_count++;
                end
                else
                begin
                    want = line_results_q.pop_front();
                    compare_field("sda_release", 8'(want.sda_release), 8'(sda_release));
                    compare_field("scl_release", 8'(want.scl_release), 8'(scl_release));
                    compare_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                    compare_field("done_res", 8'(want.done_res), 8'(done_res));
                    compare_field("acked", 8'(want.acked), 8'(acked));
                    compare_field("read_data", want.read_data, read_data);
                    compare_field("cmd_rejected", 8'(want.cmd_rejected), 8'(cmd_rejected));
                    tally_done     <= tally_done + want.done_res;
                    tally_acked    <= tally_acked + want.acked;
                    tally_rejected <= tally_rejected + want.cmd_rejected;
                end
            end
            pending    = line_results_q.size();
            bus_phase  = seq_phase;
            bus_active = (seq_phase != PH_IDLE);
        end
    end

endmodule

### tb/tb_i2c_register_access_master_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register access master: testbench top
// Drives register read and write commands followed by microsecond ticks, with
// acknowledge, read data and clock stretching shaped per transfer, random
// request gaps and result stalls; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_i2c_register_access_master_unit;
    import i2crm_pkg::*;

    localparam int NO_NACK    = -1;
    localparam int SCL_FOLLOW = 0;   // line high, rarely held low
    localparam int SCL_LOOSE  = 1;   // line level random
    localparam int SCL_HELD   = 2;   // line stuck low, stretch budget runs out
    localparam int TOTAL_ITEMS = 1800;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       cfg_we          = 1'b0;
    logic [7:0] cfg_wdata       = 8'h00;
    logic       in_valid        = 1'b0;
    logic       in_stall;
    logic [1:0] op              = OP_TICK;
    logic [7:0] device_address  = 8'h00;
    logic [7:0] register_offset = 8'h00;
    logic [7:0] write_data      = 8'h00;
    logic       sda_in          = 1'b1;
    logic       scl_in          = 1'b1;
    logic       out_valid;
    logic       out_stall       = 1'b0;
    logic       sda_release;
    logic       scl_release;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_data;
    logic       cmd_rejected;

    int         fail_count;
    int         pending;
    phase_t     bus_phase;
    logic       bus_active;
    int         tally_requests;
    int         tally_done;
    int         tally_acked;
    int         tally_rejected;

    bit         steady = 1'b0;
    int         sent_count = 0;
    int         limit_writes = 0;
    logic [7:0] cur_limit = STRETCH_LIMIT_RESET;

    always #5 clk = ~clk;

    i2c_register_access_master_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .device_address  (device_address),
        .register_offset (register_offset),
        .write_data      (write_data),
        .sda_in          (sda_in),
        .scl_in          (scl_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sda_release     (sda_release),
        .scl_release     (scl_release),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .acked           (acked),
        .read_data       (read_data),
        .cmd_rejected    (cmd_rejected)
    );

    i2c_register_access_master_unit_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .device_address  (device_address),
        .register_offset (register_offset),
        .write_data      (write_data),
        .sda_in          (sda_in),
        .scl_in          (scl_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sda_release     (sda_release),
        .scl_release     (scl_release),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .acked           (acked),
        .read_data       (read_data),
        .cmd_rejected    (cmd_rejected),
        .fail_count      (fail_count),
        .pending         (pending),
        .bus_phase       (bus_phase),
        .bus_active      (bus_active),
        .tally_requests  (tally_requests),
        .tally_done      (tally_done),
        .tally_acked     (tally_acked),
        .tally_rejected  (tally_rejected)
    );

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 33);

    // Present one request; returns at the falling edge before it is taken.
    task automatic send(input op_t code, input logic [7:0] a, input logic [7:0] o,
                        input logic [7:0] d, input logic s, input logic c);
        // no idling on either side through the middle of the run
        steady = (sent_count >= 500 && sent_count < 1000);
        if (!steady)
            while ($urandom_range(0, 99) < 33)
            begin
                @(posedge clk);
                in_valid <= 1'b0;
            end
        @(posedge clk);
        in_valid        <= 1'b1;
        op              <= code;
        device_address  <= a;
        register_offset <= o;
        write_data      <= d;
        sda_in          <= s;
        scl_in          <= c;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        @(posedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0 || bus_active)
            @(negedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = v;
        limit_writes++;
    endtask

    // One command, then ticks or odd codes until the bus goes quiet. Unless noisy,
    // the slave answers every acknowledge low except the one numbered nack_slot.
    task automatic run_transfer(input op_t code, input logic [7:0] a, input logic [7:0] o,
                                input logic [7:0] d, input int nack_slot,
                                input int scl_mode, input bit noisy, input bit stray);
        int   ack_idx;
        bit   was_ack;
        bit   in_ack;
        logic s;
        logic c;
        op_t  odd_code;
        ack_idx = 0;
        was_ack = 1'b0;
        send(code, a, o, d, 1'b1, 1'b1);
        sent_count++;
        do
        begin
            in_ack = bus_phase inside {PH_AK_A, PH_AK_B, PH_AK_C};
            if (was_ack && !in_ack)
                ack_idx++;
            was_ack = in_ack;
            if (noisy || !in_ack)
                s = 1'($urandom_range(0, 1));
            else
                s = (ack_idx == nack_slot);
            case (scl_mode)
                SCL_FOLLOW: c = ($urandom_range(0, 9) != 0);
                SCL_LOOSE:  c = 1'($urandom_range(0, 1));
                default:    c = 1'b0;
            endcase
            if (stray && $urandom_range(0, 99) < 3)
            begin
                // command or unused code while busy: must be turned away or dropped
                case ($urandom_range(0, 2))
                    0:       odd_code = OP_NONE;
                    1:       odd_code = OP_READ;
                    default: odd_code = OP_WRITE;
                endcase
                send(odd_code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), s, c);
            end
            else
                send(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), s, c);
            sent_count++;
        end
        while (bus_active);
    endtask

    initial
    begin
        int   scl_mode;
        int   nack_slot;
        op_t  code;
        logic [7:0] lim;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // idle tick and the unused code do nothing
        send(OP_TICK, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
        send(OP_NONE, 8'hff, 8'h00, 8'hff, 1'b1, 1'b1);
        run_transfer(OP_READ, 8'h00, 8'hff, 8'h00, NO_NACK, SCL_FOLLOW, 1'b0, 1'b1);
        // write data refused: stop still follows normally
        run_transfer(OP_WRITE, 8'h5a, 8'ha5, 8'h3c, 2, SCL_FOLLOW, 1'b0, 1'b0);
        // no stretch budget with SCL stuck low; read address refused after
        // the repeated start
        set_limit(8'd0);
        run_transfer(OP_READ, 8'h81, 8'h7e, 8'h18, 2, SCL_HELD, 1'b0, 1'b0);
        set_limit(8'd255);
        run_transfer(OP_READ, 8'h42, 8'hc3, 8'h00, 1, SCL_LOOSE, 1'b0, 1'b1);

        while (sent_count < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       lim = 8'd0;
                    1:       lim = 8'd255;
                    2:       lim = 8'($urandom_range(0, 8));
                    default: lim = 8'($urandom_range(0, 255));
                endcase
                set_limit(lim);
            end
            if ($urandom_range(0, 9) == 0)
                send($urandom_range(0, 1) ? OP_NONE : OP_TICK, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            code      = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            nack_slot = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 2)) : NO_NACK;
            case ($urandom_range(0, 9))
                7, 8:    scl_mode = SCL_LOOSE;
                9:       scl_mode = (cur_limit <= 8) ? SCL_HELD : SCL_LOOSE;
                default: scl_mode = SCL_FOLLOW;
            endcase
            run_transfer(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), nack_slot, scl_mode,
                         $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
        end
        steady = 1'b0;

        @(posedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("covered %0d requests: %0d transfers closed, %0d fully acknowledged",
                 tally_requests, tally_done, tally_acked);
        $display("%0d commands turned away while busy, stretch limit rewritten %0d times",
                 tally_rejected, limit_writes);
        if (fail_count == 0)
            $display("i2c_register_access_master_unit: match");
        else
            $display("i2c_register_access_master_unit: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("i2c_register_access_master_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
src/i2crm_pkg.sv
src/i2crm_in_stage.sv
src/i2crm_seq.sv
src/i2crm_out_stage.sv
src/i2c_register_access_master_unit.sv
tb/i2c_register_access_master_unit_checker.sv
tb/tb_i2c_register_access_master_unit.sv
